FILE: rtl/multilevel_queue_scheduler_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel queue scheduler
// Immediate-implication and next-cycle-implication forms on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlqs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MLQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlqs assertion failed");

`endif

FILE: rtl/mlqs_pkg.sv
// ---------------------------------------------------------------------------
// mlqs_pkg
// Widths, limits and record types shared by the scheduler files.
// ---------------------------------------------------------------------------
`default_nettype none

package mlqs_pkg;

    localparam int MAX_PROCS = 16;

    localparam int ID_W    = 16;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int LVL_W   = 2;
    localparam int TIME_W  = 22;
    localparam int SUM_W   = 28;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [LVL_W-1:0]   level;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [SUM_W-1:0]  total_turnaround;
        logic [SUM_W-1:0]  total_waiting;
        logic              overflowed;
        logic              final_result;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/mlqs_rec_if.sv
// ---------------------------------------------------------------------------
// mlqs_rec_if
// Process record channel: valid/ready handshake with the record fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface mlqs_rec_if;
    import mlqs_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    process_id;
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic [LVL_W-1:0]   queue_level;
    logic               last_item;

    modport source (
        output valid, process_id, arrival_time, burst_time, queue_level, last_item,
        input  ready
    );

    modport sink (
        input  valid, process_id, arrival_time, burst_time, queue_level, last_item,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/mlqs_res_if.sv
// ---------------------------------------------------------------------------
// mlqs_res_if
// Result channel: valid/ready handshake with one completed process.
// ---------------------------------------------------------------------------
`default_nettype none

interface mlqs_res_if;
    import mlqs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              overflowed;
    logic              final_result;

    modport source (
        output valid, done_id, completion_time, turnaround_time, waiting_time,
               total_turnaround, total_waiting, overflowed, final_result,
        input  ready
    );

    modport sink (
        input  valid, done_id, completion_time, turnaround_time, waiting_time,
               total_turnaround, total_waiting, overflowed, final_result,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/multilevel_queue_scheduler_top.sv
// ---------------------------------------------------------------------------
// multilevel_queue_scheduler_top
// Non-preemptive multilevel queue scheduler over a table of process records.
// ---------------------------------------------------------------------------
//
//  channel   role    payload                                  transactions
//  -------   ------  ---------------------------------------  ------------------
//  records   sink    id, arrival, burst, level, last_item     1 per cycle loading
//  results   source  id, ct, tat, wt, totals, ovf, final      1 per process
//
//  Cycles: records load one per cycle. After the last record each scheduling
//  decision is a scan of the record memory, one entry per cycle through its
//  single read port, then the CALC_CT, CALC_TAT and EMIT states form and
//  emit the result. An idle gap costs one extra scan pass.
//  Reset: rst_n clears control state, finished marks and sums; the record
//  memory itself is not cleared (only entries below the count are read).
//  Stalls: results backpressure holds only the emit step; a waiting result
//  does not block the loading of the next batch.
// ---------------------------------------------------------------------------
`default_nettype none

module multilevel_queue_scheduler_top (
    input  wire logic clk,
    input  wire logic rst_n,
    mlqs_rec_if.sink  records,
    mlqs_res_if.source results
);
    import mlqs_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_CALC_CT  = 5'b00100,
        S_CALC_TAT = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

    // Record memory: written while loading, read while scanning. The two
    // phases never overlap, so no forwarding is needed.
    logic [REC_W-1:0] rec_mem [MAX_PROCS];
    logic [REC_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    rec_t             wr_rec;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    done_reg, done_next;
    logic                ovf_reg, ovf_next;
    logic [TIME_W-1:0]   cur_time_reg, cur_time_next;
    logic [SUM_W-1:0]    tat_sum_reg, tat_sum_next;
    logic [SUM_W-1:0]    wt_sum_reg, wt_sum_next;
    logic [MAX_PROCS-1:0] fin_reg, fin_next;

    logic [CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                scan_vld_reg, scan_vld_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                best_found_reg, best_found_next;
    rec_t                best_rec_reg, best_rec_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]   earliest_reg, earliest_next;

    logic [TIME_W-1:0]   ct_reg, ct_next;
    logic [TIME_W-1:0]   tat_reg, tat_next;
    logic [TIME_W-1:0]   wt_reg, wt_next;

    logic                out_vld_reg, out_vld_next;
    out_item_t           out_item_reg, out_item_next;

    // Scan evaluation of the entry read last cycle
    rec_t                rec_cur;
    logic                cur_fin;
    logic                cand_ready;
    logic                cand_better;
    logic                cand_pending;
    logic                scan_last;

    // Arithmetic helpers
    logic [TIME_W:0]     ct_sum;
    logic [TIME_W-1:0]   tat_calc;
    logic [SUM_W:0]      tat_sum_add;
    logic [SUM_W:0]      wt_sum_add;
    logic [SUM_W-1:0]    tat_sum_sat;
    logic [SUM_W-1:0]    wt_sum_sat;
    logic                is_final;
    logic                rec_accept;

    assign records.ready = (state_reg == S_LOAD);
    assign rec_accept    = records.valid && records.ready;

    assign wr_rec.id      = records.process_id;
    assign wr_rec.arrival = records.arrival_time;
    assign wr_rec.burst   = records.burst_time;
    assign wr_rec.level   = records.queue_level;
    assign wr_addr        = count_reg[IDX_W-1:0];
    assign mem_we         = rec_accept && (count_reg < CNT_W'(MAX_PROCS));
    assign rd_addr        = scan_addr_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[wr_addr] <= wr_rec;
        end
        rd_data_reg <= rec_mem[rd_addr];
    end

    // Candidate test: arrived, unfinished, and better than the current best
    // (lower level, then earlier arrival; load order keeps the first seen).
    assign rec_cur     = rec_t'(rd_data_reg);
    assign cur_fin     = fin_reg[scan_idx_reg[IDX_W-1:0]];
    assign cand_ready  = scan_vld_reg && !cur_fin
                         && (TIME_W'(rec_cur.arrival) <= cur_time_reg);
    assign cand_better = !best_found_reg
                         || (rec_cur.level < best_rec_reg.level)
                         || ((rec_cur.level == best_rec_reg.level)
                             && (rec_cur.arrival < best_rec_reg.arrival));
    assign cand_pending = scan_vld_reg && !cur_fin
                          && (TIME_W'(rec_cur.arrival) < earliest_reg);
    assign scan_last   = scan_vld_reg && (scan_idx_reg == (count_reg - CNT_W'(1)));

    // Completion time saturates; turnaround never goes negative because the
    // chosen process had arrived by the start time.
    assign ct_sum   = {1'b0, cur_time_reg} + (TIME_W + 1)'(best_rec_reg.burst);
    assign tat_calc = ct_reg - TIME_W'(best_rec_reg.arrival);

    assign tat_sum_add = {1'b0, tat_sum_reg} + (SUM_W + 1)'(tat_reg);
    assign wt_sum_add  = {1'b0, wt_sum_reg} + (SUM_W + 1)'(wt_reg);
    assign tat_sum_sat = tat_sum_add[SUM_W] ? SUM_MAX : tat_sum_add[SUM_W-1:0];
    assign wt_sum_sat  = wt_sum_add[SUM_W] ? SUM_MAX : wt_sum_add[SUM_W-1:0];
    assign is_final    = ((done_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = done_reg;
        ovf_next        = ovf_reg;
        cur_time_next   = cur_time_reg;
        tat_sum_next    = tat_sum_reg;
        wt_sum_next     = wt_sum_reg;
        fin_next        = fin_reg;
        scan_addr_next  = scan_addr_reg;
        scan_vld_next   = 1'b0;
        scan_idx_next   = scan_idx_reg;
        best_found_next = best_found_reg;
        best_rec_next   = best_rec_reg;
        best_idx_next   = best_idx_reg;
        earliest_next   = earliest_reg;
        ct_next         = ct_reg;
        tat_next        = tat_reg;
        wt_next         = wt_reg;
        out_vld_next    = out_vld_reg && !results.ready;
        out_item_next   = out_item_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (rec_accept)
                begin
                    // Store while there is room; drop and flag otherwise.
                    if (mem_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (records.last_item)
                    begin
                        state_next      = S_SCAN;
                        scan_addr_next  = '0;
                        best_found_next = 1'b0;
                        earliest_next   = TIME_MAX;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read, one entry per cycle.
                if (scan_addr_reg < count_reg)
                begin
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    scan_vld_next  = 1'b1;
                    scan_idx_next  = scan_addr_reg;
                end
                if (cand_ready && cand_better)
                begin
                    best_found_next = 1'b1;
                    best_rec_next   = rec_cur;
                    best_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                if (cand_pending)
                begin
                    earliest_next = TIME_W'(rec_cur.arrival);
                end
                if (scan_last)
                begin
                    scan_addr_next = '0;
                    scan_vld_next  = 1'b0;
                    if (best_found_next)
                    begin
                        state_next = S_CALC_CT;
                    end
                    else
                    begin
                        // Idle processor: jump to the earliest pending arrival
                        // and rescan.
                        cur_time_next = earliest_next;
                        earliest_next = TIME_MAX;
                    end
                end
            end

            S_CALC_CT:
            begin
                ct_next    = ct_sum[TIME_W] ? TIME_MAX : ct_sum[TIME_W-1:0];
                state_next = S_CALC_TAT;
            end

            S_CALC_TAT:
            begin
                tat_next = tat_calc;
                wt_next  = (tat_calc > TIME_W'(best_rec_reg.burst))
                           ? tat_calc - TIME_W'(best_rec_reg.burst) : '0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Hold until the output register is free.
                if (!out_vld_reg || results.ready)
                begin
                    out_vld_next                  = 1'b1;
                    out_item_next.done_id         = best_rec_reg.id;
                    out_item_next.completion_time = ct_reg;
                    out_item_next.turnaround_time = tat_reg;
                    out_item_next.waiting_time    = wt_reg;
                    out_item_next.overflowed      = ovf_reg;
                    out_item_next.final_result    = is_final;
                    out_item_next.total_turnaround = is_final ? tat_sum_sat : '0;
                    out_item_next.total_waiting    = is_final ? wt_sum_sat : '0;

                    best_found_next = 1'b0;
                    earliest_next   = TIME_MAX;
                    scan_addr_next  = '0;

                    if (is_final)
                    begin
                        // Clear the batch for the next load.
                        state_next    = S_LOAD;
                        count_next    = '0;
                        done_next     = '0;
                        ovf_next      = 1'b0;
                        cur_time_next = '0;
                        tat_sum_next  = '0;
                        wt_sum_next   = '0;
                        fin_next      = '0;
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        done_next     = done_reg + CNT_W'(1);
                        cur_time_next = ct_reg;
                        tat_sum_next  = tat_sum_sat;
                        wt_sum_next   = wt_sum_sat;
                        fin_next[best_idx_reg] = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            done_reg       <= '0;
            ovf_reg        <= 1'b0;
            cur_time_reg   <= '0;
            tat_sum_reg    <= '0;
            wt_sum_reg     <= '0;
            fin_reg        <= '0;
            scan_addr_reg  <= '0;
            scan_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            earliest_reg   <= TIME_MAX;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            ovf_reg        <= ovf_next;
            cur_time_reg   <= cur_time_next;
            tat_sum_reg    <= tat_sum_next;
            wt_sum_reg     <= wt_sum_next;
            fin_reg        <= fin_next;
            scan_addr_reg  <= scan_addr_next;
            scan_vld_reg   <= scan_vld_next;
            best_found_reg <= best_found_next;
            earliest_reg   <= earliest_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        best_rec_reg <= best_rec_next;
        best_idx_reg <= best_idx_next;
        ct_reg       <= ct_next;
        tat_reg      <= tat_next;
        wt_reg       <= wt_next;
        out_item_reg <= out_item_next;
    end

    assign results.valid            = out_vld_reg;
    assign results.done_id          = out_item_reg.done_id;
    assign results.completion_time  = out_item_reg.completion_time;
    assign results.turnaround_time  = out_item_reg.turnaround_time;
    assign results.waiting_time     = out_item_reg.waiting_time;
    assign results.total_turnaround = out_item_reg.total_turnaround;
    assign results.total_waiting    = out_item_reg.total_waiting;
    assign results.overflowed       = out_item_reg.overflowed;
    assign results.final_result     = out_item_reg.final_result;

endmodule

`default_nettype wire

FILE: rtl/mlqs_checker.sv
// ---------------------------------------------------------------------------
// mlqs_sva
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multilevel_queue_scheduler_top_assert.svh"

module mlqs_sva (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      rec_valid,
    input wire logic                      rec_ready,
    input wire logic                      rec_last,
    input wire logic                      res_valid,
    input wire logic                      res_ready,
    input wire logic [mlqs_pkg::TIME_W-1:0] res_completion,
    input wire logic [mlqs_pkg::TIME_W-1:0] res_turnaround,
    input wire logic [mlqs_pkg::TIME_W-1:0] res_waiting,
    input wire logic [mlqs_pkg::SUM_W-1:0]  res_tot_tat,
    input wire logic [mlqs_pkg::SUM_W-1:0]  res_tot_wt,
    input wire logic                      res_final
);
    import mlqs_pkg::*;

    // A stalled result holds.
    `MLQS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_completion))

    // Waiting never exceeds turnaround, which never exceeds completion.
    `MLQS_ASSERT_NOW(a_time_order, res_valid, (res_waiting <= res_turnaround) && (res_turnaround <= res_completion))

    // Totals appear only on the final result.
    `MLQS_ASSERT_NOW(a_totals_final, res_valid && !res_final, (res_tot_tat == '0) && (res_tot_wt == '0))

    // The last record starts scheduling: loading stops.
    `MLQS_ASSERT_NEXT(a_last_stops_load, rec_valid && rec_ready && rec_last, !rec_ready)

endmodule

bind multilevel_queue_scheduler_top mlqs_sva u_mlqs_sva (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec_valid      (records.valid),
    .rec_ready      (records.ready),
    .rec_last       (records.last_item),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_completion (results.completion_time),
    .res_turnaround (results.turnaround_time),
    .res_waiting    (results.waiting_time),
    .res_tot_tat    (results.total_turnaround),
    .res_tot_wt     (results.total_waiting),
    .res_final      (results.final_result)
);

`default_nettype wire

FILE: dv/mlqs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlqs_checker
// Watches the record and result channels of the scheduler. It keeps its own
// table of process records, schedules each batch when the last record is
// accepted and compares every accepted result with the oldest expectation.
// ---------------------------------------------------------------------------

module mlqs_checker (
    input  logic        clk,
    input  logic        rst_n,
    mlqs_rec_if         records,
    mlqs_res_if         results,
    output int unsigned fail_count,
    output int unsigned pending_results
);
    import mlqs_pkg::*;

    rec_t              proc_tbl [MAX_PROCS];
    bit                done_mark [MAX_PROCS];
    int unsigned       loaded;
    logic [TIME_W-1:0] now_time;
    logic [SUM_W-1:0]  tat_total;
    logic [SUM_W-1:0]  wait_total;
    bit                dropped;

    out_item_t         expected_completions [$];
    int unsigned       mismatch_total;

    assign fail_count = mismatch_total;

    function automatic void clear_batch();
        foreach (done_mark[i])
            done_mark[i] = 1'b0;
        loaded     = 0;
        now_time   = '0;
        tat_total  = '0;
        wait_total = '0;
        dropped    = 1'b0;
    endfunction

    // Run the whole batch: whenever the processor is free, start the arrived
    // process with the lowest level, earliest arrival, then load order.
    function automatic void schedule_batch();
        int unsigned       finished;
        int                pick;
        logic [TIME_W-1:0] earliest;
        longint unsigned   ct;
        longint unsigned   tat;
        longint unsigned   wt;
        longint unsigned   sum;
        out_item_t         item;
        finished = 0;
        while (finished < loaded)
        begin
            pick = -1;
            for (int i = 0; i < int'(loaded); i++)
            begin
                if (!done_mark[i] && proc_tbl[i].arrival <= now_time)
                begin
                    if (pick < 0 || proc_tbl[i].level < proc_tbl[pick].level ||
                        (proc_tbl[i].level == proc_tbl[pick].level &&
                         proc_tbl[i].arrival < proc_tbl[pick].arrival))
                        pick = i;
                end
            end
            if (pick < 0)
            begin
                // Idle processor: jump to the earliest unfinished arrival.
                earliest = TIME_MAX;
                for (int i = 0; i < int'(loaded); i++)
                begin
                    if (!done_mark[i] && proc_tbl[i].arrival < earliest)
                        earliest = proc_tbl[i].arrival;
                end
                now_time = earliest;
            end
            else
            begin
                ct = now_time + proc_tbl[pick].burst;
                if (ct > TIME_MAX)
                    ct = TIME_MAX;
                tat = ct - proc_tbl[pick].arrival;
                wt  = (tat > proc_tbl[pick].burst) ? tat - proc_tbl[pick].burst : 0;
                now_time = TIME_W'(ct);
                done_mark[pick] = 1'b1;
                sum = tat_total + tat;
                tat_total = (sum > SUM_MAX) ? SUM_MAX : SUM_W'(sum);
                sum = wait_total + wt;
                wait_total = (sum > SUM_MAX) ? SUM_MAX : SUM_W'(sum);
                finished++;

                item = '0;
                item.done_id         = proc_tbl[pick].id;
                item.completion_time = TIME_W'(ct);
                item.turnaround_time = TIME_W'(tat);
                item.waiting_time    = TIME_W'(wt);
                item.overflowed      = dropped;
                if (finished == loaded)
                begin
                    item.total_turnaround = tat_total;
                    item.total_waiting    = wait_total;
                    item.final_result     = 1'b1;
                end
                expected_completions.push_back(item);
            end
        end
        clear_batch();
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        rec_t      rec;
        if (!rst_n)
        begin
            clear_batch();
            expected_completions.delete();
            mismatch_total = 0;
            pending_results <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_completions.size() == 0)
                begin
                    $error("unexpected result transaction, done_id %0d",
                           results.done_id);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_completions.pop_front();
                    check_field("done_id", want.done_id, results.done_id);
                    check_field("completion_time", want.completion_time,
                                results.completion_time);
                    check_field("turnaround_time", want.turnaround_time,
                                results.turnaround_time);
                    check_field("waiting_time", want.waiting_time,
                                results.waiting_time);
                    check_field("total_turnaround", want.total_turnaround,
                                results.total_turnaround);
                    check_field("total_waiting", want.total_waiting,
                                results.total_waiting);
                    check_field("overflowed", want.overflowed, results.overflowed);
                    check_field("final_result", want.final_result,
                                results.final_result);
                end
            end

            if (records.valid && records.ready)
            begin
                rec.id      = records.process_id;
                rec.arrival = records.arrival_time;
                rec.burst   = records.burst_time;
                rec.level   = records.queue_level;
                // Store while there is room; otherwise drop and flag it.
                if (loaded < MAX_PROCS)
                begin
                    proc_tbl[loaded]  = rec;
                    done_mark[loaded] = 1'b0;
                    loaded++;
                end
                else
                    dropped = 1'b1;
                if (records.last_item)
                    schedule_batch();
            end

            pending_results <= expected_completions.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Batches of process records go into the multilevel queue scheduler with
// random gaps on the record side and random stalls on the result side; a
// checker beside the block predicts every completion and compares it.
// ---------------------------------------------------------------------------

module tb_top;
    import mlqs_pkg::*;

    // No transaction on either channel for this long means the block hung.
    // The slowest legal gap is the long result hold plus one scheduling
    // decision (two scans of the table and the emit), far below this.
    localparam int unsigned STALL_LIMIT  = 5000;
    // Cycles to keep watching after the last expected result, enough for a
    // full scan pass plus emit, to catch any extra result.
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_ITEMS = 245;
    // The long result hold starts at this result, inside the random part, so
    // that the sender is still offering records while the block backs up.
    localparam int unsigned HOLD_AT      = 30;
    localparam int unsigned LONG_HOLD    = 400;

    // Shapes of a random batch: crowded arrivals make the levels and ties
    // matter, spread arrivals leave the processor idle, anything is full range.
    typedef enum {CROWDED, SPREAD, ANYTHING} batch_shape_t;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned idle_cycles;
    bit          sender_quiet;

    mlqs_rec_if rec_ch ();
    mlqs_res_if res_ch ();

    multilevel_queue_scheduler_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (rec_ch.sink),
        .results (res_ch.source)
    );

    mlqs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .records         (rec_ch),
        .results         (res_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: count cycles with no transaction on either channel.
    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one record. Enter and leave at a falling edge; hold valid and the
    // payload until the block takes the transaction.
    task automatic send_record(input logic [ID_W-1:0] pid,
                               input logic [ARR_W-1:0] arr,
                               input logic [BURST_W-1:0] bur,
                               input logic [LVL_W-1:0] lvl,
                               input bit last);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rec_ch.valid        <= 1'b1;
        rec_ch.process_id   <= pid;
        rec_ch.arrival_time <= arr;
        rec_ch.burst_time   <= bur;
        rec_ch.queue_level  <= lvl;
        rec_ch.last_item    <= last;
        do
            @(posedge clk);
        while (!rec_ch.ready);
        @(negedge clk);
    endtask

    // One random batch; returns the number of records offered. About one
    // batch in eight runs past the table size so that records are dropped.
    task automatic send_random_batch(output int unsigned offered);
        int unsigned        size;
        batch_shape_t       shape;
        bit                 one_level;
        logic [LVL_W-1:0]   lvl_fixed;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bur;
        logic [LVL_W-1:0]   lvl;
        if ($urandom_range(0, 7) == 0)
            size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
        else if ($urandom_range(0, 3) == 0)
            size = 1;
        else
            size = $urandom_range(2, MAX_PROCS);
        shape        = batch_shape_t'($urandom_range(0, 2));
        one_level    = ($urandom_range(0, 4) == 0);
        lvl_fixed    = LVL_W'($urandom_range(0, 3));
        sender_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < int'(size); i++)
        begin
            case (shape)
                CROWDED:
                begin
                    arr = ARR_W'($urandom_range(0, 63));
                    bur = BURST_W'($urandom_range(0, 40));
                end
                SPREAD:
                begin
                    arr = ARR_W'($urandom_range(0, 65535));
                    bur = BURST_W'($urandom_range(0, 2000));
                end
                default:
                begin
                    arr = ARR_W'($urandom_range(0, 65535));
                    bur = BURST_W'($urandom_range(0, 65535));
                end
            endcase
            lvl = one_level ? lvl_fixed : LVL_W'($urandom_range(0, 3));
            send_record(ID_W'($urandom_range(0, 65535)), arr, bur, lvl,
                        i == int'(size) - 1);
        end
        offered = size;
    endtask

    // Result side: draw a stall per result, with quiet stretches, and one
    // long hold counted here while the sender keeps going.
    initial
    begin : result_sink
        int unsigned taken;
        int unsigned stall;
        bit          quiet;
        taken = 0;
        quiet = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 8 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT)
                stall = LONG_HOLD;
            else
                stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : record_source
        int unsigned random_sent;
        int unsigned offered;
        random_sent         = 0;
        sender_quiet        = 1'b0;
        rst_n               = 1'b0;
        rec_ch.valid        = 1'b0;
        rec_ch.process_id   = '0;
        rec_ch.arrival_time = '0;
        rec_ch.burst_time   = '0;
        rec_ch.queue_level  = '0;
        rec_ch.last_item    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single record at the top of every range: the processor idles until
        // the latest possible arrival, then runs the longest burst.
        send_record(16'h0000, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1);

        // All arrive at once on four different levels, loaded highest level
        // first; zero and full bursts, extreme ids.
        send_record(16'hFFFF, 16'h0000, 16'h0000, 2'd3, 1'b0);
        send_record(16'h0000, 16'h0000, 16'hFFFF, 2'd2, 1'b0);
        send_record(16'h1234, 16'h0000, 16'h0001, 2'd1, 1'b0);
        send_record(16'hABCD, 16'h0000, 16'h0007, 2'd0, 1'b1);

        // Nothing arrived at time zero, so jump ahead; equal level and
        // arrival go by load order; a late low-level record forces a second
        // idle jump after the others finish.
        send_record(16'd10, 16'd100, 16'd5, 2'd1, 1'b0);
        send_record(16'd11, 16'd100, 16'd5, 2'd1, 1'b0);
        send_record(16'd12, 16'd5000, 16'd0, 2'd0, 1'b0);
        send_record(16'd13, 16'd100, 16'd0, 2'd1, 1'b1);

        // Fill the table with the longest bursts, then drop the final record:
        // scheduling must still start, with the overflow flag on every result.
        for (int i = 0; i < MAX_PROCS; i++)
            send_record(ID_W'(16'h8000 + i), (i % 2 == 0) ? 16'h0000 : 16'hFFFF,
                        16'hFFFF, LVL_W'(i % 4), 1'b0);
        send_record(16'h7FFF, 16'h0000, 16'h0001, 2'd0, 1'b1);

        while (random_sent < RANDOM_ITEMS)
        begin
            send_random_batch(offered);
            random_sent += offered;
        end
        rec_ch.valid <= 1'b0;

        // Drain: wait for every predicted result, then watch a little longer
        // for anything extra before giving the verdict.
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mlqs_pkg.sv
rtl/mlqs_rec_if.sv
rtl/mlqs_res_if.sv
rtl/multilevel_queue_scheduler_top.sv
rtl/mlqs_checker.sv
dv/mlqs_checker.sv
dv/tb_top.sv
